// ===== rtl/lud_pkg.sv =====
// Shared types and constants for the LU decompose and solve block.
package lud_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned ORDER_LIMIT = 16;
  localparam int unsigned DIV_STEPS   = 48;

  // Configuration register indexes
  localparam int unsigned REG_MATRIX_SIZE = 0;

  typedef enum logic [1:0] {
    MODE_MAT   = 2'd0,
    MODE_RHS   = 2'd1,
    MODE_SOLVE = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  // Decoded command of one accepted input transfer
  typedef struct packed {
    logic wr_mat;
    logic wr_rhs;
    logic start_solve;
  } lud_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_F_PIV_RD,
    ST_F_PIV,
    ST_F_L_RD,
    ST_F_L_DIV,
    ST_F_L_WAIT,
    ST_F_J_RD,
    ST_F_J_MAC,
    ST_F_J_WAIT,
    ST_FW_RD,
    ST_FW_LOAD,
    ST_FW_J_RD,
    ST_FW_J_MAC,
    ST_FW_J_WAIT,
    ST_FW_STORE,
    ST_BK_RD,
    ST_BK_LOAD,
    ST_BK_J_RD,
    ST_BK_J_MAC,
    ST_BK_J_WAIT,
    ST_BK_DRD,
    ST_BK_DIV,
    ST_BK_DWAIT,
    ST_OUT_RD,
    ST_OUT_SEND
  } lud_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_FIN
  } div_state_e;

endpackage

// ===== rtl/lud_mac.sv =====
// Shared Q16.16 multiply-subtract unit: res = sat(acc - sat(round(a * b))).
module lud_mac import lud_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [WORD_W-1:0] a_i,
  input  logic signed [WORD_W-1:0] b_i,
  input  logic signed [WORD_W-1:0] acc_i,
  output logic                     done_o,
  output logic signed [WORD_W-1:0] res_o
);

  logic [1:0]               vld_q;
  logic signed [63:0]       prod_q;
  logic signed [WORD_W-1:0] acc_q;
  logic signed [WORD_W-1:0] res_q;
  logic signed [63:0]       rnd;
  logic signed [WORD_W-1:0] prod_sat;
  logic signed [WORD_W:0]   diff;
  logic signed [WORD_W-1:0] res_d;

  // Track the two pipeline stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[0], start_i};
    end
  end

  // Register the full product
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= 64'(a_i) * 64'(b_i);
      acc_q  <= acc_i;
    end
    if (vld_q[0]) begin
      res_q <= res_d;
    end
  end

  // Round to nearest with ties up, saturate, then subtract and saturate
  always_comb begin
    rnd = (prod_q + 64'sd32768) >>> 16;
    if (rnd > 64'sd2147483647) begin
      prod_sat = 32'sh7fffffff;
    end else if (rnd < -64'sd2147483648) begin
      prod_sat = 32'sh80000000;
    end else begin
      prod_sat = WORD_W'(rnd);
    end
    diff = 33'(acc_q) - 33'(prod_sat);
    if (diff > 33'sd2147483647) begin
      res_d = 32'sh7fffffff;
    end else if (diff < -33'sd2147483648) begin
      res_d = 32'sh80000000;
    end else begin
      res_d = WORD_W'(diff);
    end
  end

  assign done_o = vld_q[1];
  assign res_o  = res_q;

endmodule

// ===== rtl/lud_div.sv =====
// Shared Q16.16 divider: (a * 65536) / b, truncated toward zero, one quotient bit a cycle.
module lud_div import lud_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [WORD_W-1:0] a_i,
  input  logic signed [WORD_W-1:0] b_i,
  output logic                     done_o,
  output logic signed [WORD_W-1:0] quot_o
);

  localparam int unsigned CW = $clog2(DIV_STEPS);

  div_state_e               state_q, state_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic                     done_q, done_d;
  logic [WORD_W-1:0]        rem_q, rem_d;
  logic [DIV_STEPS-1:0]     quo_q, quo_d;
  logic [WORD_W-1:0]        den_q, den_d;
  logic                     neg_q, neg_d;
  logic                     zero_q, zero_d;
  logic signed [WORD_W-1:0] res_q, res_d;
  logic [WORD_W:0]          rem_sh;
  logic [WORD_W-1:0]        mag_a;
  logic [WORD_W-1:0]        mag_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
    res_q  <= res_d;
  end

  // Sequence the restoring steps on magnitudes, then sign and saturate (zero for a zero divisor)
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    neg_d   = neg_q;
    zero_d  = zero_q;
    res_d   = res_q;
    mag_a   = a_i[WORD_W-1] ? (~a_i + 1'b1) : a_i;
    mag_b   = b_i[WORD_W-1] ? (~b_i + 1'b1) : b_i;
    rem_sh  = {rem_q, quo_q[DIV_STEPS-1]};
    case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          rem_d   = '0;
          quo_d   = {mag_a, 16'h0000};
          den_d   = mag_b;
          neg_d   = a_i[WORD_W-1] ^ b_i[WORD_W-1];
          zero_d  = (b_i == '0);
          cnt_d   = '0;
          state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (rem_sh >= {1'b0, den_q}) begin
          rem_d = WORD_W'(rem_sh - {1'b0, den_q});
          quo_d = {quo_q[DIV_STEPS-2:0], 1'b1};
        end else begin
          rem_d = WORD_W'(rem_sh);
          quo_d = {quo_q[DIV_STEPS-2:0], 1'b0};
        end
        if (cnt_q == CW'(DIV_STEPS - 1)) begin
          state_d = DIV_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      DIV_FIN: begin
        if (zero_q) begin
          res_d = '0;
        end else if (neg_q) begin
          if (quo_q > DIV_STEPS'(64'h80000000)) begin
            res_d = 32'sh80000000;
          end else begin
            res_d = WORD_W'(~quo_q[WORD_W-1:0] + 1'b1);
          end
        end else if (quo_q > DIV_STEPS'(64'h7fffffff)) begin
          res_d = 32'sh7fffffff;
        end else begin
          res_d = WORD_W'(quo_q[WORD_W-1:0]);
        end
        done_d  = 1'b1;
        state_d = DIV_IDLE;
      end
      default: begin
        state_d = DIV_IDLE;
      end
    endcase
  end

  assign done_o = done_q;
  assign quot_o = res_q;

endmodule

// ===== rtl/lud_core.sv =====
// Stores, sequencer and result register of the LU decompose and solve block.
module lud_core import lud_pkg::*; #(
  parameter int MAX_ORDER = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lud_cmd_t                 cmd_i,
  input  logic [3:0]               row_i,
  input  logic [3:0]               col_i,
  input  logic signed [WORD_W-1:0] value_i,
  input  logic [CNT_W-1:0]         n_i,
  output logic                     idle_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [3:0]               index_o,
  output logic signed [WORD_W-1:0] solution_o,
  output logic                     singular_o,
  output logic                     last_o
);

  localparam int DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_ORDER);

  function automatic logic [AW-1:0] mat_addr(input logic [CNT_W-1:0] r,
                                             input logic [CNT_W-1:0] c);
    mat_addr = AW'(AW'(r) * AW'(MAX_ORDER) + AW'(c));
  endfunction

  // Stores
  logic signed [WORD_W-1:0] mat_mem [DEPTH];
  logic signed [WORD_W-1:0] rhs_mem [MAX_ORDER];
  logic signed [WORD_W-1:0] x_mem   [MAX_ORDER];

  lud_state_e               state_q, state_d;
  logic [CNT_W-1:0]         k_q, k_d, i_q, i_d, j_q, j_d;
  logic                     sing_q, sing_d;
  logic signed [WORD_W-1:0] piv_q, piv_d, l_q, l_d, acc_q, acc_d;
  logic                     out_vld_q, out_vld_d;
  logic [3:0]               out_idx_q;
  logic signed [WORD_W-1:0] out_sol_q;
  logic                     out_sing_q, out_last_q;
  logic                     out_load;

  logic [AW-1:0]            ra0, ra1, mat_wa;
  logic [RW-1:0]            xra, rra, x_wa;
  logic                     mat_we, x_we;
  logic signed [WORD_W-1:0] mat_wd, x_wd;
  logic signed [WORD_W-1:0] rd0_q, rd1_q, x_rd_q, rhs_rd_q;

  logic                     mac_start, mac_done;
  logic signed [WORD_W-1:0] mac_a, mac_b, mac_acc, mac_res;
  logic                     div_start, div_done;
  logic signed [WORD_W-1:0] div_a, div_b, div_q;
  logic                     ld_ok;

  lud_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .a_i     (mac_a),
    .b_i     (mac_b),
    .acc_i   (mac_acc),
    .done_o  (mac_done),
    .res_o   (mac_res)
  );

  lud_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (div_a),
    .b_i     (div_b),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  // Drop load writes outside the stores
  assign ld_ok = (int'(row_i) < MAX_ORDER) && (int'(col_i) < MAX_ORDER);

  // Write and read the stores, read data registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_mat && ld_ok) begin
      mat_mem[mat_addr({1'b0, row_i}, {1'b0, col_i})] <= value_i;
    end else if (mat_we) begin
      mat_mem[mat_wa] <= mat_wd;
    end
    if (cmd_i.wr_rhs && (int'(row_i) < MAX_ORDER)) begin
      rhs_mem[RW'(row_i)] <= value_i;
    end
    if (x_we) begin
      x_mem[x_wa] <= x_wd;
    end
    rd0_q    <= mat_mem[ra0];
    rd1_q    <= mat_mem[ra1];
    x_rd_q   <= x_mem[xra];
    rhs_rd_q <= rhs_mem[rra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      k_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      sing_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      i_q       <= i_d;
      j_q       <= j_d;
      sing_q    <= sing_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    piv_q <= piv_d;
    l_q   <= l_d;
    acc_q <= acc_d;
    if (out_load) begin
      out_idx_q  <= 4'(i_q);
      out_sol_q  <= x_rd_q;
      out_sing_q <= sing_q;
      out_last_q <= (i_q + 1'b1) == n_i;
    end
  end

  // Sequence factoring, forward and back substitution and output
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    i_d       = i_q;
    j_d       = j_q;
    sing_d    = sing_q;
    piv_d     = piv_q;
    l_d       = l_q;
    acc_d     = acc_q;
    ra0       = mat_addr(i_q, j_q);
    ra1       = mat_addr(i_q, j_q);
    xra       = RW'(j_q);
    rra       = RW'(i_q);
    mat_we    = 1'b0;
    mat_wa    = mat_addr(i_q, j_q);
    mat_wd    = mac_res;
    x_we      = 1'b0;
    x_wa      = RW'(i_q);
    x_wd      = acc_q;
    mac_start = 1'b0;
    mac_a     = rd0_q;
    mac_b     = x_rd_q;
    mac_acc   = acc_q;
    div_start = 1'b0;
    div_a     = rd0_q;
    div_b     = piv_q;
    out_load  = 1'b0;
    out_vld_d = out_vld_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (cmd_i.start_solve) begin
          k_d     = '0;
          sing_d  = 1'b0;
          state_d = ST_F_PIV_RD;
        end
      end
      ST_F_PIV_RD: begin
        ra0     = mat_addr(k_q, k_q);
        state_d = ST_F_PIV;
      end
      ST_F_PIV: begin
        piv_d = rd0_q;
        if (rd0_q == '0) begin
          sing_d = 1'b1;
        end
        if ((k_q + 1'b1) == n_i) begin
          i_d     = '0;
          state_d = ST_FW_RD;
        end else begin
          i_d     = k_q + 1'b1;
          state_d = ST_F_L_RD;
        end
      end
      ST_F_L_RD: begin
        ra0     = mat_addr(i_q, k_q);
        state_d = ST_F_L_DIV;
      end
      ST_F_L_DIV: begin
        div_start = 1'b1;
        state_d   = ST_F_L_WAIT;
      end
      ST_F_L_WAIT: begin
        if (div_done) begin
          l_d     = div_q;
          mat_we  = 1'b1;
          mat_wa  = mat_addr(i_q, k_q);
          mat_wd  = div_q;
          j_d     = k_q + 1'b1;
          state_d = ST_F_J_RD;
        end
      end
      ST_F_J_RD: begin
        ra0     = mat_addr(k_q, j_q);
        ra1     = mat_addr(i_q, j_q);
        state_d = ST_F_J_MAC;
      end
      ST_F_J_MAC: begin
        mac_start = 1'b1;
        mac_a     = l_q;
        mac_b     = rd0_q;
        mac_acc   = rd1_q;
        state_d   = ST_F_J_WAIT;
      end
      ST_F_J_WAIT: begin
        if (mac_done) begin
          mat_we = 1'b1;
          if ((j_q + 1'b1) != n_i) begin
            j_d     = j_q + 1'b1;
            state_d = ST_F_J_RD;
          end else if ((i_q + 1'b1) != n_i) begin
            i_d     = i_q + 1'b1;
            state_d = ST_F_L_RD;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_F_PIV_RD;
          end
        end
      end
      ST_FW_RD: begin
        state_d = ST_FW_LOAD;
      end
      ST_FW_LOAD: begin
        acc_d = rhs_rd_q;
        j_d   = '0;
        if (i_q == '0) begin
          state_d = ST_FW_STORE;
        end else begin
          state_d = ST_FW_J_RD;
        end
      end
      ST_FW_J_RD: begin
        state_d = ST_FW_J_MAC;
      end
      ST_FW_J_MAC: begin
        mac_start = 1'b1;
        state_d   = ST_FW_J_WAIT;
      end
      ST_FW_J_WAIT: begin
        if (mac_done) begin
          acc_d = mac_res;
          if ((j_q + 1'b1) == i_q) begin
            state_d = ST_FW_STORE;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = ST_FW_J_RD;
          end
        end
      end
      ST_FW_STORE: begin
        x_we = 1'b1;
        if ((i_q + 1'b1) == n_i) begin
          state_d = ST_BK_RD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_FW_RD;
        end
      end
      ST_BK_RD: begin
        xra     = RW'(i_q);
        state_d = ST_BK_LOAD;
      end
      ST_BK_LOAD: begin
        acc_d = x_rd_q;
        j_d   = i_q + 1'b1;
        if ((i_q + 1'b1) == n_i) begin
          state_d = ST_BK_DRD;
        end else begin
          state_d = ST_BK_J_RD;
        end
      end
      ST_BK_J_RD: begin
        state_d = ST_BK_J_MAC;
      end
      ST_BK_J_MAC: begin
        mac_start = 1'b1;
        state_d   = ST_BK_J_WAIT;
      end
      ST_BK_J_WAIT: begin
        if (mac_done) begin
          acc_d = mac_res;
          if ((j_q + 1'b1) == n_i) begin
            state_d = ST_BK_DRD;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = ST_BK_J_RD;
          end
        end
      end
      ST_BK_DRD: begin
        ra0     = mat_addr(i_q, i_q);
        state_d = ST_BK_DIV;
      end
      ST_BK_DIV: begin
        div_start = 1'b1;
        div_a     = acc_q;
        div_b     = rd0_q;
        state_d   = ST_BK_DWAIT;
      end
      ST_BK_DWAIT: begin
        if (div_done) begin
          x_we = 1'b1;
          x_wd = div_q;
          if (i_q == '0) begin
            state_d = ST_OUT_RD;
          end else begin
            i_d     = i_q - 1'b1;
            state_d = ST_BK_RD;
          end
        end
      end
      ST_OUT_RD: begin
        xra     = RW'(i_q);
        state_d = ST_OUT_SEND;
      end
      ST_OUT_SEND: begin
        // Hold the read until the result register frees up
        xra = RW'(i_q);
        if (!out_vld_q || out_ready_i) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          if ((i_q + 1'b1) == n_i) begin
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign idle_o      = (state_q == ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign index_o     = out_idx_q;
  assign solution_o  = out_sol_q;
  assign singular_o  = out_sing_q;
  assign last_o      = out_last_q;

endmodule

// ===== rtl/lu_decompose_solve_top.sv =====
// A solve of order n runs n*(n-1)/2 divisions for the multipliers, (n-1)*n*(2n-1)/6 +
// n*(n-1) multiply-subtracts and n divisions for the back substitution, then sends n
// results; the 48-step shared divider and the shared multiply-subtract unit do this work.
// One item at a time: in_ready_o is high only while the sequencer is idle.
// Reset (async, active low) sets matrix_size to 4 and idles the sequencer; stores are not cleared.
module lu_decompose_solve_top import lud_pkg::*; #(
  parameter int MAX_ORDER = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [1:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               mode_i,
  input  logic [3:0]               row_i,
  input  logic [3:0]               col_i,
  input  logic signed [WORD_W-1:0] element_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [3:0]               index_o,
  output logic signed [WORD_W-1:0] solution_o,
  output logic                     singular_o,
  output logic                     last_o
);

  localparam int NMAX = (MAX_ORDER < int'(ORDER_LIMIT)) ? MAX_ORDER : int'(ORDER_LIMIT);

  logic [CNT_W-1:0] size_q;
  logic [CNT_W-1:0] n_eff;
  logic             idle;
  logic             in_xfer;
  lud_cmd_t         cmd;

  // Write the order register on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= CNT_W'(4);
    end else if (psel && penable && pwrite && (32'(paddr >> 2) == REG_MATRIX_SIZE)) begin
      size_q <= pwdata[CNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = 32'(size_q);

  // Clamp the order to the supported range
  always_comb begin
    if (size_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(size_q) > NMAX) begin
      n_eff = CNT_W'(NMAX);
    end else begin
      n_eff = size_q;
    end
  end

  // Decode the accepted input transfer
  assign in_ready_o = idle;
  assign in_xfer    = in_valid_i && idle;

  always_comb begin
    cmd = '0;
    if (in_xfer) begin
      case (mode_e'(mode_i))
        MODE_MAT:   cmd.wr_mat      = 1'b1;
        MODE_RHS:   cmd.wr_rhs      = 1'b1;
        MODE_SOLVE: cmd.start_solve = 1'b1;
        default:    cmd             = '0;
      endcase
    end
  end

  lud_core #(
    .MAX_ORDER (MAX_ORDER)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .row_i       (row_i),
    .col_i       (col_i),
    .value_i     (element_value_i),
    .n_i         (n_eff),
    .idle_o      (idle),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .index_o     (index_o),
    .solution_o  (solution_o),
    .singular_o  (singular_o),
    .last_o      (last_o)
  );

endmodule

// ===== tb/sv/lu_decompose_solve_top_tb.sv =====
// Self-checking testbench for the LU decompose and solve block.
`timescale 1ns / 1ps

module lu_decompose_solve_top_tb import lud_pkg::*;;

  localparam int unsigned NORD      = 16;
  localparam int unsigned IDLE_MAX  = 200000;
  localparam int unsigned LONG_HOLD = 3000;
  localparam int unsigned ITEM_GOAL = 420;
  localparam int unsigned SETTLE    = 40;

  typedef struct packed {
    logic [3:0]  index;
    logic [31:0] solution;
    logic        singular;
    logic        last;
  } solution_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [31:0] value;
    logic        typed;
    logic [31:0] x;
    logic        sing;
  } table_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = '0;
  logic [3:0]  row_i = '0;
  logic [3:0]  col_i = '0;
  logic signed [31:0] element_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  index_o;
  logic signed [31:0] solution_o;
  logic        singular_o;
  logic        last_o;

  lu_decompose_solve_top #(.MAX_ORDER(NORD)) DUT (.*);

  always #10 clk_i = ~clk_i;

  // Predictor state: order register, stores and which entries hold data
  logic [4:0] order_reg;
  int         mat_q [NORD][NORD];
  int         rhs_q [NORD];
  int         part_q [NORD];
  bit         mat_set [NORD][NORD];
  bit         rhs_set [NORD];
  int         sol_vec [NORD];
  bit         sol_sing;

  solution_t  pending_q [$];
  int         mismatches = 0;
  int         results_seen = 0;
  int         solves_sent = 0;
  int         items_sent = 0;
  int         big_solves = 0;
  bit         valid_on = 1'b0;
  bit         hold_req = 1'b0;
  int         gap_left = 0;
  int         burst_left = 0;

  function automatic int fx_sat(longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  // Exact product, round half up, i.e. floor of (p + half)
  function automatic int fx_mul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b) + 64'sd32768;
    return fx_sat(p >>> 16);
  endfunction

  function automatic int fx_div(int a, int b);
    if (b == 0) return 0;
    return fx_sat((longint'(a) * 64'sd65536) / longint'(b));
  endfunction

  function automatic int fx_sub(int a, int b);
    return fx_sat(longint'(a) - longint'(b));
  endfunction

  function automatic int active_order();
    if (order_reg == 0) return 1;
    if (order_reg > NORD) return NORD;
    return order_reg;
  endfunction

  // Factor in place, forward then back substitution; leaves x in sol_vec
  function automatic int lu_solve_predict();
    int n, piv, l, acc;
    n = active_order();
    sol_sing = 1'b0;
    for (int k = 0; k < n; k++) begin
      piv = mat_q[k][k];
      if (piv == 0) sol_sing = 1'b1;
      for (int i = k + 1; i < n; i++) begin
        l = fx_div(mat_q[i][k], piv);
        mat_q[i][k] = l;
        for (int j = k + 1; j < n; j++)
          mat_q[i][j] = fx_sub(mat_q[i][j], fx_mul(l, mat_q[k][j]));
      end
    end
    for (int i = 0; i < n; i++) begin
      acc = rhs_q[i];
      for (int j = 0; j < i; j++) acc = fx_sub(acc, fx_mul(mat_q[i][j], part_q[j]));
      part_q[i] = acc;
    end
    for (int i = n - 1; i >= 0; i--) begin
      acc = part_q[i];
      for (int j = i + 1; j < n; j++) acc = fx_sub(acc, fx_mul(mat_q[i][j], part_q[j]));
      part_q[i] = fx_div(acc, mat_q[i][i]);
    end
    for (int i = 0; i < n; i++) sol_vec[i] = part_q[i];
    return n;
  endfunction

  function automatic void push_solutions(int n, bit typed, int x, bit sing);
    solution_t s;
    for (int i = 0; i < n; i++) begin
      s.index    = 4'(i);
      s.solution = typed ? x : sol_vec[i];
      s.singular = typed ? sing : sol_sing;
      s.last     = (i == n - 1);
      pending_q  = {pending_q, s};
    end
  endfunction

  // Offer one item in bursts with random gaps; update the predictor on transfer
  task automatic send_item(logic [1:0] mode, logic [3:0] row, logic [3:0] col,
                           logic [31:0] value, bit typed = 1'b0,
                           logic [31:0] x = '0, bit sing = 1'b0);
    int n;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
    end
    if (gap_left > 0) begin
      if (valid_on) in_valid_i <= 1'b0;
      valid_on = 1'b0;
      repeat (gap_left) @(posedge clk_i);
      gap_left = 0;
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    valid_on        = 1'b1;
    mode_i          <= mode;
    row_i           <= row;
    col_i           <= col;
    element_value_i <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    case (mode)
      MODE_MAT: begin
        mat_q[row][col] = value;
        mat_set[row][col] = 1'b1;
      end
      MODE_RHS: begin
        rhs_q[row] = value;
        rhs_set[row] = 1'b1;
      end
      MODE_SOLVE: begin
        n = lu_solve_predict();
        push_solutions(n, typed, x, sing);
        solves_sent++;
        if (n == NORD) big_solves++;
      end
      default: ;
    endcase
  endtask

  task automatic stop_sending();
    if (valid_on) in_valid_i <= 1'b0;
    valid_on = 1'b0;
  endtask

  // Wait until every solution has come back, then let the block settle
  task automatic drain();
    stop_sending();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_order(logic [4:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 2'(REG_MATRIX_SIZE * 4);
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    order_reg = value;
  endtask

  function automatic logic [31:0] pick_value(int n, bit diag);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFFFFFF;
          1: return 32'h80000000;
          2: return 32'h0;
          default: return 32'hFFFFFFFF;
        endcase
      end
      default: begin
        if (diag)
          return ($urandom_range(0, 1) ? 1 : -1) * (n * 65536 * 2 + $urandom_range(0, 262143));
        return $urandom_range(0, 524287) - 262144;
      end
    endcase
  endfunction

  // Load a full system of order n in random order with some noise mixed in
  task automatic load_system(int n);
    int cnt;
    int perm [$];
    for (int i = 0; i < n * n; i++) perm = {perm, i};
    perm.shuffle();
    foreach (perm[p]) begin
      send_item(MODE_MAT, 4'(perm[p] / n), 4'(perm[p] % n),
                pick_value(n, (perm[p] / n) == (perm[p] % n)));
      if ($urandom_range(0, 15) == 0)
        send_item($urandom_range(0, 1) ? MODE_NONE : MODE_MAT, 4'($urandom),
                  4'($urandom), $urandom());
    end
    for (int i = 0; i < n; i++) send_item(MODE_RHS, 4'(i), 4'($urandom), pick_value(n, 0));
    // occasional zero pivot
    if ($urandom_range(0, 7) == 0) begin
      cnt = $urandom_range(0, n - 1);
      send_item(MODE_MAT, 4'(cnt), 4'(cnt), 32'h0);
    end
  endtask

  task automatic fill_unset(int n);
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++)
        if (!mat_set[r][c]) send_item(MODE_MAT, 4'(r), 4'(c), pick_value(n, r == c));
      if (!rhs_set[r]) send_item(MODE_RHS, 4'(r), 4'(0), pick_value(n, 0));
    end
  endtask

  // Receiver: stall pattern of its own, long hold on request, check each transfer
  int        rx_left = 0;
  int        rx_kind = 0;
  int        hold_left = 0;
  solution_t want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected solution idx=%0d x=%h", index_o, solution_o);
        end else begin
          want = pending_q.pop_front();
          if (index_o !== want.index || solution_o !== want.solution ||
              singular_o !== want.singular || last_o !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"solution mismatch exp idx=%0d x=%h sing=%b last=%b",
                        " got idx=%0d x=%h sing=%b last=%b"},
                       want.index, want.solution, want.singular, want.last,
                       index_o, solution_o, singular_o, last_o);
          end
        end
      end
      if (hold_req && hold_left == 0) begin
        hold_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_kind = $urandom_range(0, 2);
          rx_left = (rx_kind == 2) ? $urandom_range(1, 12) : $urandom_range(10, 80);
        end
        rx_left--;
        case (rx_kind)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= 1'b0;
        endcase
      end
    end
  end

  // Watchdog on cycles without any transfer
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == IDLE_MAX) begin
        $display("timeout after %0d idle cycles", IDLE_MAX);
        $display("lu_decompose_solve_top: mismatch");
        $finish;
      end
    end
  end

  // Directed rows at order 1: identity, zero pivot, saturation, ignored mode
  table_row_t dir_tab [] = '{
    '{MODE_MAT,   0,  0, 32'h00010000, 0, 0, 0},
    '{MODE_RHS,   0,  0, 32'h00050000, 0, 0, 0},
    '{MODE_SOLVE, 0,  0, 32'h0,        1, 32'h00050000, 0},
    '{MODE_MAT,   0,  0, 32'h0,        0, 0, 0},
    '{MODE_SOLVE, 0,  0, 32'h0,        1, 32'h0, 1},
    '{MODE_MAT,   0,  0, 32'h00000001, 0, 0, 0},
    '{MODE_RHS,   0,  0, 32'h7FFFFFFF, 0, 0, 0},
    '{MODE_SOLVE, 0,  0, 32'h0,        1, 32'h7FFFFFFF, 0},
    '{MODE_RHS,   0,  0, 32'h80000000, 0, 0, 0},
    '{MODE_SOLVE, 0,  0, 32'h0,        1, 32'h80000000, 0},
    '{MODE_MAT,  15, 15, 32'h7FFFFFFF, 0, 0, 0},
    '{MODE_MAT,  15,  0, 32'h80000000, 0, 0, 0},
    '{MODE_RHS,  15, 15, 32'hFFFFFFFF, 0, 0, 0},
    '{MODE_NONE, 15, 15, 32'hFFFFFFFF, 0, 0, 0},
    '{MODE_MAT,   0,  0, 32'hFFFF0000, 0, 0, 0},
    '{MODE_RHS,   0,  0, 32'h00030000, 0, 0, 0},
    '{MODE_SOLVE, 0,  0, 32'h0,        1, 32'hFFFD0000, 0},
    '{MODE_MAT,   0,  0, 32'h7FFFFFFF, 0, 0, 0},
    '{MODE_RHS,   0,  0, 32'h80000000, 0, 0, 0},
    '{MODE_SOLVE, 0,  0, 32'h0,        0, 0, 0}
  };

  initial begin
    int n, phase, rep;
    logic [4:0] raw;
    order_reg = 5'd4;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part
    write_order(5'd1);
    foreach (dir_tab[t])
      send_item(dir_tab[t].mode, dir_tab[t].row, dir_tab[t].col, dir_tab[t].value,
                dir_tab[t].typed, dir_tab[t].x, dir_tab[t].sing);
    drain();

    // Random phases; mostly small orders, the largest order in two phases
    phase = 0;
    while (phase < 7 || items_sent < ITEM_GOAL) begin
      if (phase == 5) raw = 5'd16;
      else if (phase == 6) raw = 5'd31;
      else if (phase == 3) raw = 5'd4;
      else begin
        case ($urandom_range(0, 7))
          0: raw = 5'd0;
          1: raw = 5'd8;
          2: raw = 5'd1;
          default: raw = 5'($urandom_range(2, 5));
        endcase
      end
      write_order(raw);
      n = active_order();
      if (phase == 6) begin
        // solve the stored factors again at an out-of-range order
        fill_unset(n);
        send_item(MODE_SOLVE, 4'($urandom), 4'($urandom), $urandom());
      end else begin
        rep = (phase == 3) ? 2 : (n >= 8) ? 1 : $urandom_range(1, 3);
        for (int s = 0; s < rep; s++) begin
          if (s == 0 || $urandom_range(0, 3) != 0) load_system(n);
          else send_item(MODE_MAT, 4'($urandom_range(0, n - 1)),
                         4'($urandom_range(0, n - 1)), pick_value(n, 0));
          fill_unset(n);
          send_item(MODE_SOLVE, 4'($urandom), 4'($urandom), $urandom());
          // hold off the receiver while the next system is offered
          if (phase == 3 && s == 0) hold_req = 1'b1;
          if (phase == 2 && s == 0) begin
            // pause until everything solved is back
            stop_sending();
            while (pending_q.size() != 0) @(posedge clk_i);
          end
        end
      end
      drain();
      phase++;
    end

    drain();
    $display("covered %0d items, %0d solves (%0d at full order), %0d solutions checked",
             items_sent, solves_sent, big_solves, results_seen);
    if (mismatches == 0) begin
      $display("lu_decompose_solve_top: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("lu_decompose_solve_top: mismatch");
    end
    $finish;
  end

endmodule
